### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a rising clock edge. An active-low reset turns it off.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("stream assertion failed");

// The same check on the block's own clock and reset.
`define ASSERT_ACLK(label, prop) `ASSERT_CLK(label, aclk, aresetn, prop)

`endif

### src/scld_pkg.sv
package scld_pkg;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Command prefixes in ASCII, first character in the upper byte.
    localparam logic [55:0] CMD_TM   = "SET_TM=";
    localparam logic [71:0] CMD_TIME = 72'h53_45_54_5F_54_49_4D_45_3D;
    localparam int TM_LEN        = 7;
    localparam int TIME_LEN      = 9;
    localparam int TIME_TEXT_LEN = 8;

    localparam logic [5:0] PERIOD_MIN = 6'd2;
    localparam logic [5:0] PERIOD_MAX = 6'd60;
    localparam logic [6:0] HOUR_MAX   = 7'd23;
    localparam logic [6:0] MINSEC_MAX = 7'd59;

    localparam logic [2:0] ST_PERIOD_SET = 3'd0;
    localparam logic [2:0] ST_PERIOD_ERR = 3'd1;
    localparam logic [2:0] ST_TIME_SET   = 3'd2;
    localparam logic [2:0] ST_TIME_FMT   = 3'd3;
    localparam logic [2:0] ST_TIME_RANGE = 3'd4;
    localparam logic [2:0] ST_UNKNOWN    = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic       term;
        logic [7:0] ch;
    } q_item_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_push_t;

    // Packed so that status sits in the lowest bits.
    typedef struct packed {
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [5:0] period_seconds;
        logic [2:0] status;
    } result_t;

    typedef struct packed {
        logic       reject;
        logic [6:0] value;
    } pair_num_t;

    typedef enum logic [1:0] {BK_IDLE, BK_WALK, BK_FINISH} back_state_t;
    typedef enum logic [1:0] {NUM_SKIP, NUM_DIGIT, NUM_END} num_state_t;

    function automatic logic is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_VT ||
               c == CHAR_FF || c == CHAR_CR;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return c == CHAR_PLUS || c == CHAR_MINUS;
    endfunction

    function automatic logic [7:0] cmd_tm_char(input logic [2:0] i);
        logic [55:0] sh;
        sh = CMD_TM << {i, 3'b000};
        return sh[55:48];
    endfunction

    function automatic logic [7:0] cmd_time_char(input logic [3:0] i);
        logic [71:0] sh;
        sh = CMD_TIME << {i, 3'b000};
        return sh[71:64];
    endfunction

    // A time field is two characters followed by a colon or the line end, so
    // the whole number parse reduces to these two characters.
    function automatic pair_num_t pair_number(input logic [7:0] c0, input logic [7:0] c1);
        pair_num_t r;
        r = '0;
        priority if (is_blank(c0)) begin
            if (is_digit(c1)) r.value = {3'b000, c1[3:0]};
        end else if (is_sign(c0)) begin
            if (is_digit(c1)) begin
                r.value  = {3'b000, c1[3:0]};
                r.reject = (c0 == CHAR_MINUS) && (c1[3:0] != 4'd0);
            end
        end else if (is_digit(c0)) begin
            if (is_digit(c1)) begin
                r.value = 7'({3'b000, c0[3:0]} * 7'd10 + {3'b000, c1[3:0]});
            end else begin
                r.value = {3'b000, c0[3:0]};
            end
        end else begin
            r.value = '0;
        end
        return r;
    endfunction

endpackage

### src/scld_front.sv
module scld_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    output scld_pkg::q_push_t q_push,
    input  logic             q_ready
);
    import scld_pkg::*;

    logic    vld_reg, vld_next;
    q_item_t item_reg;

    assign s_tready = !vld_reg || q_ready;

    always_comb begin
        if (s_tvalid && s_tready) begin
            vld_next = 1'b1;
        end else begin
            vld_next = vld_reg && !q_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Line terminators are tagged here so the back end never compares bytes twice.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.ch   <= s_tdata;
            item_reg.term <= (s_tdata == CHAR_CR) || (s_tdata == CHAR_LF);
        end
    end

    assign q_push.valid = vld_reg;
    assign q_push.item  = item_reg;

endmodule

### src/scld_queue.sv
module scld_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  scld_pkg::q_push_t push,
    output logic              push_ready,
    output logic              pop_valid,
    output scld_pkg::q_item_t pop_item,
    input  logic              pop_en
);
    import scld_pkg::*;

    q_item_t           entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = cnt_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = entries[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop_en && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push.item;
        end
    end

endmodule

### src/scld_back.sv
module scld_back #(
    parameter int LINE_BYTES = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    input  scld_pkg::q_item_t pop_item,
    output logic              pop_en,
    output logic              out_valid,
    input  logic              out_ready,
    output scld_pkg::result_t out_result
);
    import scld_pkg::*;

    localparam int AW = $clog2(LINE_BYTES);
    localparam logic [AW-1:0] FILL_MAX  = AW'(LINE_BYTES - 1);
    localparam logic [AW-1:0] TM_POS    = AW'(TM_LEN);
    localparam logic [AW-1:0] TIME_POS  = AW'(TIME_LEN);
    localparam logic [AW-1:0] TIME_LINE = AW'(TIME_LEN + TIME_TEXT_LEN);
    localparam logic [AW-1:0] POS_H0    = AW'(TIME_LEN);
    localparam logic [AW-1:0] POS_H1    = AW'(TIME_LEN + 1);
    localparam logic [AW-1:0] POS_C0    = AW'(TIME_LEN + 2);
    localparam logic [AW-1:0] POS_M0    = AW'(TIME_LEN + 3);
    localparam logic [AW-1:0] POS_M1    = AW'(TIME_LEN + 4);
    localparam logic [AW-1:0] POS_C1    = AW'(TIME_LEN + 5);
    localparam logic [AW-1:0] POS_S0    = AW'(TIME_LEN + 6);
    localparam logic [AW-1:0] POS_S1    = AW'(TIME_LEN + 7);

    logic [7:0] line_mem [LINE_BYTES];

    back_state_t state_reg, state_next;
    logic [AW-1:0] fill_reg, fill_next;
    logic [AW-1:0] issue_reg, issue_next;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] len_reg, len_next;
    logic          dv_reg;
    logic [7:0]    rd_data_reg;

    logic       tm_match_reg, tm_match_next;
    logic       time_match_reg, time_match_next;
    num_state_t num_st_reg, num_st_next;
    logic       num_neg_reg, num_neg_next;
    logic       num_big_reg, num_big_next;
    logic [5:0] num_val_reg, num_val_next;
    logic [7:0] tb_reg [6];
    logic [7:0] tb_next [6];
    logic       col0_reg, col0_next;
    logic       col1_reg, col1_next;

    logic    out_vld_reg, out_vld_next;
    result_t out_reg, res;

    logic walk_start, mem_we, iss_on, proc_byte, walk_done, load_out;
    logic [9:0] prod;
    pair_num_t h_num, m_num, s_num;
    logic tm_cmd, time_cmd;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (pop_valid && pop_item.term && fill_reg != '0) state_next = BK_WALK;
            end
            BK_WALK: begin
                if (walk_done) state_next = BK_FINISH;
            end
            BK_FINISH: begin
                if (len_reg == '0 || !out_vld_reg || out_ready) state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        pop_en     = (state_reg == BK_IDLE) && pop_valid;
        walk_start = pop_en && pop_item.term && fill_reg != '0;
        mem_we     = pop_en && !pop_item.term && fill_reg != FILL_MAX;
        iss_on     = (state_reg == BK_WALK) && issue_reg != fill_reg;
        proc_byte  = (state_reg == BK_WALK) && dv_reg && rd_data_reg != CHAR_NUL;
        walk_done  = (state_reg == BK_WALK) && dv_reg &&
                     (rd_data_reg == CHAR_NUL || pos_reg == fill_reg - 1'b1);
        load_out   = (state_reg == BK_FINISH) && len_reg != '0 &&
                     (!out_vld_reg || out_ready);
    end

    // Line bookkeeping and the per-byte parser.
    always_comb begin
        fill_next       = fill_reg;
        issue_next      = issue_reg;
        len_next        = len_reg;
        tm_match_next   = tm_match_reg;
        time_match_next = time_match_reg;
        num_st_next     = num_st_reg;
        num_neg_next    = num_neg_reg;
        num_big_next    = num_big_reg;
        num_val_next    = num_val_reg;
        tb_next         = tb_reg;
        col0_next       = col0_reg;
        col1_next       = col1_reg;
        prod            = 10'(num_val_reg) * 10'd10 + 10'(rd_data_reg[3:0]);

        if (mem_we) fill_next = fill_reg + 1'b1;
        if (state_reg == BK_FINISH && state_next == BK_IDLE) fill_next = '0;
        if (iss_on) issue_next = issue_reg + 1'b1;
        if (walk_done) len_next = (rd_data_reg == CHAR_NUL) ? pos_reg : fill_reg;

        if (walk_start) begin
            issue_next      = '0;
            tm_match_next   = 1'b1;
            time_match_next = 1'b1;
            num_st_next     = NUM_SKIP;
            num_neg_next    = 1'b0;
            num_big_next    = 1'b0;
            num_val_next    = '0;
            col0_next       = 1'b0;
            col1_next       = 1'b0;
        end

        if (proc_byte) begin
            if (pos_reg < TM_POS) begin
                tm_match_next = tm_match_reg && (rd_data_reg == cmd_tm_char(pos_reg[2:0]));
            end
            if (pos_reg < TIME_POS) begin
                time_match_next = time_match_reg &&
                                  (rd_data_reg == cmd_time_char(pos_reg[3:0]));
            end
            if (pos_reg == POS_H0) tb_next[0] = rd_data_reg;
            if (pos_reg == POS_H1) tb_next[1] = rd_data_reg;
            if (pos_reg == POS_M0) tb_next[2] = rd_data_reg;
            if (pos_reg == POS_M1) tb_next[3] = rd_data_reg;
            if (pos_reg == POS_S0) tb_next[4] = rd_data_reg;
            if (pos_reg == POS_S1) tb_next[5] = rd_data_reg;
            if (pos_reg == POS_C0) col0_next = rd_data_reg == CHAR_COLON;
            if (pos_reg == POS_C1) col1_next = rd_data_reg == CHAR_COLON;

            // Period number: any value above the top of the range is kept only as a flag.
            if (pos_reg >= TM_POS) begin
                unique case (num_st_reg)
                    NUM_SKIP: begin
                        priority if (is_blank(rd_data_reg)) begin
                            num_st_next = NUM_SKIP;
                        end else if (is_sign(rd_data_reg)) begin
                            num_st_next  = NUM_DIGIT;
                            num_neg_next = rd_data_reg == CHAR_MINUS;
                        end else if (is_digit(rd_data_reg)) begin
                            num_st_next = NUM_DIGIT;
                            if (prod > 10'(PERIOD_MAX)) num_big_next = 1'b1;
                            else num_val_next = prod[5:0];
                        end else begin
                            num_st_next = NUM_END;
                        end
                    end
                    NUM_DIGIT: begin
                        if (is_digit(rd_data_reg)) begin
                            if (!num_big_reg) begin
                                if (prod > 10'(PERIOD_MAX)) num_big_next = 1'b1;
                                else num_val_next = prod[5:0];
                            end
                        end else begin
                            num_st_next = NUM_END;
                        end
                    end
                    NUM_END: num_st_next = NUM_END;
                    default: num_st_next = NUM_END;
                endcase
            end
        end
    end

    // Line decision.
    always_comb begin
        res      = '0;
        h_num    = pair_number(tb_reg[0], tb_reg[1]);
        m_num    = pair_number(tb_reg[2], tb_reg[3]);
        s_num    = pair_number(tb_reg[4], tb_reg[5]);
        tm_cmd   = tm_match_reg && len_reg >= TM_POS;
        time_cmd = time_match_reg && len_reg >= TIME_POS;
        priority if (tm_cmd) begin
            if (!num_neg_reg && !num_big_reg && num_val_reg >= PERIOD_MIN &&
                num_val_reg <= PERIOD_MAX) begin
                res.status         = ST_PERIOD_SET;
                res.period_seconds = num_val_reg;
            end else begin
                res.status = ST_PERIOD_ERR;
            end
        end else if (time_cmd) begin
            if (len_reg != TIME_LINE || !col0_reg || !col1_reg) begin
                res.status = ST_TIME_FMT;
            end else if (h_num.reject || m_num.reject || s_num.reject ||
                         h_num.value > HOUR_MAX || m_num.value > MINSEC_MAX ||
                         s_num.value > MINSEC_MAX) begin
                res.status = ST_TIME_RANGE;
            end else begin
                res.status  = ST_TIME_SET;
                res.hours   = h_num.value[4:0];
                res.minutes = m_num.value[5:0];
                res.seconds = s_num.value[5:0];
            end
        end else begin
            res.status = ST_UNKNOWN;
        end
    end

    always_comb begin
        if (load_out) begin
            out_vld_next = 1'b1;
        end else begin
            out_vld_next = out_vld_reg && !out_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            fill_reg    <= '0;
            issue_reg   <= '0;
            dv_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            issue_reg   <= issue_next;
            dv_reg      <= iss_on;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= issue_reg;
        len_reg        <= len_next;
        tm_match_reg   <= tm_match_next;
        time_match_reg <= time_match_next;
        num_st_reg     <= num_st_next;
        num_neg_reg    <= num_neg_next;
        num_big_reg    <= num_big_next;
        num_val_reg    <= num_val_next;
        tb_reg         <= tb_next;
        col0_reg       <= col0_next;
        col1_reg       <= col1_next;
        if (load_out) out_reg <= res;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) line_mem[fill_reg] <= pop_item.ch;
        if (iss_on) rd_data_reg <= line_mem[issue_reg];
    end

    assign out_valid  = out_vld_reg;
    assign out_result = out_reg;

endmodule

### src/serial_command_line_decoder.sv
// Decodes text commands arriving one character per transaction on the s_ channel.
// Characters are collected in a line buffer of LINE_BYTES-1 bytes; extra ones are
// dropped. CR or LF closes the line and yields at most one result on the m_ channel
// (nothing for an empty line): SET_TM=n sets a 2..60 s period, the time command
// sets a time of day; the status field tells which command and whether it was accepted.
// The input stage and a four-entry queue take one character per cycle, so the
// sender is only held off while the queue is full.
// Ordinary characters leave the queue at one per cycle while the back end is idle.
// A terminator starts a walk of the buffer through one memory read port, one byte
// per cycle; the result is registered after the walk, and characters keep queuing.
// The result sits in an output register. If m_tready stays low, the result is
// held and the next finished line waits behind it, then the queue fills and
// s_tready drops. Reset empties the line buffer, queue and output register.
module serial_command_line_decoder #(
    parameter int LINE_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [2:0] status, [8:3] period_seconds, [13:9] hours,
                                   // [19:14] minutes, [25:20] seconds, [31:26] zero
);
    import scld_pkg::*;

    q_push_t push;
    logic    push_ready;
    logic    pop_valid;
    q_item_t pop_item;
    logic    pop_en;
    result_t result;

    scld_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_push   (push),
        .q_ready  (push_ready)
    );

    scld_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_en     (pop_en)
    );

    scld_back #(
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_en     (pop_en),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {6'b000000, result};

endmodule

### src/scld_checker.sv
`include "assert_macros.svh"

module scld_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import scld_pkg::*;

    `ASSERT_ACLK(a_valid_held, m_tvalid && !m_tready |=> m_tvalid)
    `ASSERT_ACLK(a_data_held, m_tvalid && !m_tready |=> $stable(m_tdata))
    `ASSERT_ACLK(a_status_known, m_tvalid |-> m_tdata[2:0] <= ST_UNKNOWN && m_tdata[31:26] == 6'd0)
    `ASSERT_ACLK(a_period_field, m_tvalid |-> ((m_tdata[2:0] == ST_PERIOD_SET) ? (m_tdata[8:3] >= PERIOD_MIN && m_tdata[8:3] <= PERIOD_MAX) : (m_tdata[8:3] == 6'd0)))
    `ASSERT_ACLK(a_time_field, m_tvalid && m_tdata[2:0] != ST_TIME_SET |-> m_tdata[25:9] == 17'd0)

endmodule

bind serial_command_line_decoder scld_checker u_scld_checker (.*);

### verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import scld_pkg::*;

    localparam int          LINE_BYTES   = 32;
    localparam int          RESET_CYCLES = 12;
    localparam int          RANDOM_ITEMS = 120;
    localparam int          LONG_HOLD    = 400;
    localparam int          TAIL_CYCLES  = 64;
    localparam int          LIMIT_CYCLES = 400000;
    localparam int          MAX_PRINTED  = 50;
    localparam int unsigned NUMBER_CAP    = 100000;
    localparam int unsigned NUMBER_REJECT = 32'hFFFF_FFFF;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // Line store of the predictor and the replies it still waits for.
    logic [7:0]  line_buf [LINE_BYTES];
    int unsigned line_fill = 0;
    result_t     pending_replies [$];
    logic [7:0]  draft [$];

    int          error_count  = 0;
    int unsigned chars_taken  = 0;
    int unsigned cycle_count  = 0;
    int unsigned tx_gap_max   = 9;
    int unsigned rx_stall_max = 9;
    int unsigned hold_orders  = 0;
    int unsigned hold_served  = 0;
    int unsigned hold_left    = 0;
    int unsigned rx_gap       = 0;

    serial_command_line_decoder #(
        .LINE_BYTES(LINE_BYTES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("ERROR at %0t ns: %s", $realtime, msg);
        end
    endtask

    function automatic bit skips_as_blank(logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_VT ||
               c == CHAR_FF || c == CHAR_CR;
    endfunction

    // Prefix of the time-of-day command as text.
    function automatic string clock_cmd_text();
        return $sformatf("%s", CMD_TIME);
    endfunction

    // Reads a number the way atoi does; a negative nonzero or an oversized value
    // comes back as NUMBER_REJECT.
    function automatic int unsigned parse_number(int unsigned pos, int unsigned len);
        int unsigned p;
        int unsigned v;
        bit          neg;
        p   = pos;
        v   = 0;
        neg = 1'b0;
        while (p < len && skips_as_blank(line_buf[p])) p++;
        if (p < len && (line_buf[p] == CHAR_PLUS || line_buf[p] == CHAR_MINUS)) begin
            neg = line_buf[p] == CHAR_MINUS;
            p++;
        end
        while (p < len && line_buf[p] >= CHAR_ZERO && line_buf[p] <= CHAR_NINE) begin
            if (v < NUMBER_CAP) v = v * 10 + int'(line_buf[p] - CHAR_ZERO);
            p++;
        end
        if (v >= NUMBER_CAP || (neg && v != 0)) return NUMBER_REJECT;
        return v;
    endfunction

    function automatic bit decode_stored_line(output result_t r);
        int unsigned len;
        int unsigned n;
        int unsigned h;
        int unsigned m;
        int unsigned s;
        bit          tm_cmd;
        bit          time_cmd;
        r   = '0;
        len = 0;
        while (len < line_fill && line_buf[len] != CHAR_NUL) len++;
        if (len == 0) return 1'b0;
        tm_cmd   = len >= TM_LEN;
        time_cmd = len >= TIME_LEN;
        for (int i = 0; i < TIME_LEN; i++) begin
            if (i < TM_LEN && i < len && line_buf[i] != CMD_TM[8*(TM_LEN-1-i) +: 8]) begin
                tm_cmd = 1'b0;
            end
            if (i < len && line_buf[i] != CMD_TIME[8*(TIME_LEN-1-i) +: 8]) begin
                time_cmd = 1'b0;
            end
        end
        if (tm_cmd) begin
            n = parse_number(TM_LEN, len);
            if (n >= PERIOD_MIN && n <= PERIOD_MAX) begin
                r.status         = ST_PERIOD_SET;
                r.period_seconds = n[5:0];
            end else begin
                r.status = ST_PERIOD_ERR;
            end
        end else if (time_cmd) begin
            if (len != TIME_LEN + TIME_TEXT_LEN || line_buf[TIME_LEN+2] != CHAR_COLON ||
                line_buf[TIME_LEN+5] != CHAR_COLON) begin
                r.status = ST_TIME_FMT;
            end else begin
                h = parse_number(TIME_LEN, len);
                m = parse_number(TIME_LEN + 3, len);
                s = parse_number(TIME_LEN + 6, len);
                if (h > HOUR_MAX || m > MINSEC_MAX || s > MINSEC_MAX) begin
                    r.status = ST_TIME_RANGE;
                end else begin
                    r.status  = ST_TIME_SET;
                    r.hours   = h[4:0];
                    r.minutes = m[5:0];
                    r.seconds = s[5:0];
                end
            end
        end else begin
            r.status = ST_UNKNOWN;
        end
        return 1'b1;
    endfunction

    function automatic void take_char(logic [7:0] c);
        result_t r;
        if (c == CHAR_CR || c == CHAR_LF) begin
            if (decode_stored_line(r)) pending_replies.push_back(r);
            line_fill = 0;
        end else if (line_fill < LINE_BYTES - 1) begin
            line_buf[line_fill] = c;
            line_fill++;
        end
        chars_taken++;
    endfunction

    // Receiver: drives m_tready and checks every result transaction.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[25:0];
                if (pending_replies.size() == 0) begin
                    report_mismatch($sformatf("result 0x%08h with no line pending", m_tdata));
                end else begin
                    want = pending_replies.pop_front();
                    if (got.status != want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.period_seconds != want.period_seconds)
                        report_mismatch($sformatf("period %0d, expected %0d",
                                                  got.period_seconds, want.period_seconds));
                    if (got.hours != want.hours)
                        report_mismatch($sformatf("hours %0d, expected %0d",
                                                  got.hours, want.hours));
                    if (got.minutes != want.minutes)
                        report_mismatch($sformatf("minutes %0d, expected %0d",
                                                  got.minutes, want.minutes));
                    if (got.seconds != want.seconds)
                        report_mismatch($sformatf("seconds %0d, expected %0d",
                                                  got.seconds, want.seconds));
                    if (m_tdata[31:26] != '0)
                        report_mismatch($sformatf("padding bits 0x%02h not zero",
                                                  m_tdata[31:26]));
                end
                rx_gap = $urandom_range(0, rx_stall_max);
            end
            if (hold_orders != hold_served) begin
                hold_served = hold_orders;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Keeps s_tvalid high across back-to-back transactions when no gap is drawn.
    task automatic send_char(logic [7:0] c);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        take_char(c);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic send_line(string s);
        send_text(s);
        send_char(CHAR_LF);
    endtask

    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_VT;
            default: return CHAR_FF;
        endcase
    endfunction

    function automatic logic [7:0] pick_plain_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CHAR_CR || c == CHAR_LF);
        return c;
    endfunction

    function automatic void add_string(string s);
        for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
    endfunction

    function automatic void add_number_text();
        int unsigned v;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 2)) draft.push_back(pick_blank());
        end
        case ($urandom_range(0, 7))
            0: draft.push_back(CHAR_PLUS);
            1: draft.push_back(CHAR_MINUS);
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 3);
            1: v = $urandom_range(57, 63);
            2: v = $urandom_range(NUMBER_CAP - 2, NUMBER_CAP + 1);
            3: v = $urandom_range(0, 1999999);
            default: v = $urandom_range(0, 99);
        endcase
        if ($urandom_range(0, 9) == 0) return;
        if ($urandom_range(0, 7) == 0) draft.push_back(CHAR_ZERO);
        add_string($sformatf("%0d", v));
        if ($urandom_range(0, 7) == 0) draft.push_back(pick_plain_byte());
    endfunction

    function automatic void add_time_field(int unsigned top);
        int unsigned v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: draft.push_back(pick_blank());
                    1: draft.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                    2: draft.push_back(pick_plain_byte());
                    default: draft.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                endcase
                if ($urandom_range(0, 3) == 0) draft.push_back(pick_plain_byte());
                else draft.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
            end
            1: begin
                v = $urandom_range(top, top + 1);
                add_string($sformatf("%02d", v));
            end
            2: add_string($sformatf("%02d", $urandom_range(0, 99)));
            default: add_string($sformatf("%02d", $urandom_range(0, top)));
        endcase
    endfunction

    function automatic void build_period_line();
        add_string("SET_TM=");
        add_number_text();
    endfunction

    function automatic void build_time_line();
        add_string(clock_cmd_text());
        add_time_field(HOUR_MAX);
        draft.push_back(CHAR_COLON);
        add_time_field(MINSEC_MAX);
        draft.push_back(CHAR_COLON);
        add_time_field(MINSEC_MAX);
        case ($urandom_range(0, 11))
            0: void'(draft.pop_back());
            1: draft.push_back(pick_plain_byte());
            2: draft[TIME_LEN + ($urandom_range(0, 1) ? 2 : 5)] = pick_plain_byte();
            3: draft[$urandom_range(0, draft.size() - 1)] = CHAR_NUL;
            default: ;
        endcase
    endfunction

    task automatic send_draft();
        foreach (draft[i]) send_char(draft[i]);
        send_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        draft.delete();
    endtask

    task automatic test_period_commands();
        send_line("SET_TM=2");
        send_text("SET_TM=60");
        send_char(CHAR_CR);
        send_line("SET_TM=1");
        send_line("SET_TM=61");
        send_text("SET_TM= ");
        send_char(CHAR_TAB);
        send_char(CHAR_VT);
        send_char(CHAR_FF);
        send_line("+07");
        send_line("SET_TM=-0");
        send_line("SET_TM=-5");
        send_line("SET_TM=9999999");
        send_line("SET_TM=");
        send_line("SET_TM=30abc");
    endtask

    task automatic test_time_commands();
        send_line({clock_cmd_text(), "00:00:00"});
        send_line({clock_cmd_text(), "23:59:59"});
        send_line({clock_cmd_text(), "24:00:00"});
        send_line({clock_cmd_text(), "12:60:00"});
        send_line({clock_cmd_text(), "00:00:60"});
        send_line({clock_cmd_text(), "-1:00:00"});
        send_line({clock_cmd_text(), " 7:+5:-0"});
        send_line({clock_cmd_text(), "12:34:5"});
        send_line({clock_cmd_text(), "12:34:567"});
        send_line({clock_cmd_text(), "12-34:56"});
        send_line({clock_cmd_text(), "ab:cd:ef"});
    endtask

    task automatic test_line_framing();
        // Empty lines and a line that starts with NUL must not produce anything.
        send_char(CHAR_LF);
        send_char(CHAR_CR);
        send_char(CHAR_NUL);
        send_line("SET_TM=5");
        send_text("SET_TM=45");
        send_char(CHAR_NUL);
        send_line("xyz");
        // The store keeps 31 bytes, so the trailing nines are dropped.
        send_text("SET_TM=");
        repeat (22) send_char(CHAR_SPACE);
        send_line("459999");
        send_text({clock_cmd_text(), "01:02:03"});
        repeat (20) send_char(8'hFF);
        send_char(CHAR_LF);
        send_text("HELLO");
        send_char(8'hFF);
        send_char(8'h80);
        send_char(CHAR_LF);
        send_line("set_tm=5");
    endtask

    task automatic test_output_stall();
        tx_gap_max = 0;
        hold_orders <= hold_orders + 1;
        for (int i = 0; i < 4; i++) send_line($sformatf("SET_TM=%0d", 2 + 15 * i));
        for (int i = 0; i < 2; i++) begin
            send_line({clock_cmd_text(), $sformatf("%02d:%02d:%02d", i, i, i)});
        end
        tx_gap_max = 9;
    endtask

    task automatic test_drain_pause();
        send_line("SET_TM=17");
        send_line({clock_cmd_text(), "09:08:07"});
        wait_for_replies();
        send_line("SET_TM=3");
        send_line("BOGUS");
    endtask

    task automatic test_random_lines();
        int unsigned start;
        start = chars_taken;
        while (chars_taken < start + RANDOM_ITEMS) begin
            tx_gap_max   = ($urandom_range(0, 5) == 0) ? 0 : 9;
            rx_stall_max = ($urandom_range(0, 5) == 0) ? 0 : 9;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6: build_period_line();
                7, 8, 9, 10, 11, 12, 13: build_time_line();
                14, 15: begin
                    repeat ($urandom_range(1, 40)) draft.push_back(8'($urandom_range(0, 255)));
                end
                16, 17: begin
                    if ($urandom_range(0, 1)) build_period_line();
                    else build_time_line();
                    draft[$urandom_range(0, TM_LEN - 1)] = pick_plain_byte();
                end
                18: begin
                    add_string("SET_TM=");
                    repeat ($urandom_range(18, 30)) draft.push_back(pick_blank());
                    add_number_text();
                end
                default: ;
            endcase
            send_draft();
        end
        tx_gap_max   = 9;
        rx_stall_max = 9;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_period_commands();
        test_time_commands();
        test_line_framing();
        test_output_stall();
        test_drain_pause();
        test_random_lines();
        wait_for_replies();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
